FILE: rtl/rfsr_pkg.sv
package rfsr_pkg;

	localparam int NUM_REFS  = 16;
	localparam int SLOT_W    = (NUM_REFS > 1) ? $clog2(NUM_REFS) : 1;
	localparam int FRAME_W   = 16;
	localparam int OFFSET_W  = 8;
	localparam int NEW_OFF_W = 4;
	localparam int BEST_W    = NEW_OFF_W + 1;

	localparam logic [OFFSET_W-1:0]  OFFSET_NONE  = 8'hff;
	localparam logic [NEW_OFF_W-1:0] SEARCH_LIMIT = 4'hf;
	// one past the search limit marks "no substitute found yet"
	localparam logic [BEST_W-1:0]    NO_SUBST     = {1'b1, {NEW_OFF_W{1'b0}}};

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [FRAME_W-1:0] frame_t;

	typedef enum logic {
		OP_ADD     = 1'b0,
		OP_RESOLVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_PRESENT = 2'd1,
		ST_SUBST   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef struct packed {
		logic   wr_en;
		frame_t wr_data;
		logic   rd_en;
		slot_t  rd_slot;
	} store_cmd_t;

	typedef struct packed {
		logic   vld;
		logic   hit;
		frame_t data;
	} store_rsp_t;

endpackage

FILE: rtl/rfsr_store.sv
module rfsr_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rfsr_pkg::store_cmd_t  cmd,
	output rfsr_pkg::store_rsp_t  rsp
);

	localparam logic [rfsr_pkg::SLOT_W:0] DEPTH = rfsr_pkg::NUM_REFS[rfsr_pkg::SLOT_W:0];

	rfsr_pkg::frame_t ref_mem [rfsr_pkg::NUM_REFS];

	rfsr_pkg::slot_t base_q;
	logic [rfsr_pkg::NUM_REFS-1:0] valid_q;
	logic rsp_vld_q;
	logic rsp_hit_q;
	rfsr_pkg::frame_t rsp_data_q;

	rfsr_pkg::slot_t empty_slot;
	rfsr_pkg::slot_t base_dec;
	rfsr_pkg::slot_t wr_addr;
	rfsr_pkg::slot_t rd_addr;

	// logical slot to physical address: (base + slot) mod depth
	function automatic rfsr_pkg::slot_t slot_wrap(rfsr_pkg::slot_t base, rfsr_pkg::slot_t s);
		logic [rfsr_pkg::SLOT_W:0] sum;
		sum = {1'b0, base} + {1'b0, s};
		if (sum >= DEPTH) begin
			sum = sum - DEPTH;
		end
		return sum[rfsr_pkg::SLOT_W-1:0];
	endfunction

	always_comb begin
		empty_slot = '0;
		// highest empty logical slot wins
		for (int i = 0; i < rfsr_pkg::NUM_REFS; i++) begin
			if (!valid_q[i]) begin
				empty_slot = rfsr_pkg::slot_t'(i);
			end
		end
		base_dec = (base_q == '0) ? rfsr_pkg::slot_t'(rfsr_pkg::NUM_REFS - 1) : base_q - 1'b1;
		// a shift only moves the base; the dropped last slot is the one rewritten
		wr_addr = valid_q[0] ? base_dec : slot_wrap(base_q, empty_slot);
		rd_addr = slot_wrap(base_q, cmd.rd_slot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			valid_q   <= '0;
			rsp_vld_q <= 1'b0;
			rsp_hit_q <= 1'b0;
		end else begin
			rsp_vld_q <= cmd.rd_en;
			rsp_hit_q <= valid_q[cmd.rd_slot];
			if (cmd.wr_en) begin
				if (valid_q[0]) begin
					base_q  <= base_dec;
					valid_q <= {valid_q[rfsr_pkg::NUM_REFS-2:0], 1'b1};
				end else begin
					valid_q[empty_slot] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			ref_mem[wr_addr] <= cmd.wr_data;
		end
		rsp_data_q <= ref_mem[rd_addr];
	end

	assign rsp = '{vld: rsp_vld_q, hit: rsp_hit_q, data: rsp_data_q};

endmodule

FILE: rtl/rfsr_match.sv
module rfsr_match (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  rfsr_pkg::store_rsp_t               rsp,
	input  rfsr_pkg::frame_t                   cur,
	input  logic [rfsr_pkg::OFFSET_W-1:0]      off,
	output logic                               present,
	output logic [rfsr_pkg::BEST_W-1:0]        best
);

	logic present_q;
	logic [rfsr_pkg::BEST_W-1:0] best_q;

	rfsr_pkg::frame_t gap;
	logic entry_live;
	logic is_exact;
	logic is_cand;

	always_comb begin
		// offset at which this stored frame would sit: cur - 1 - frame
		gap        = cur - rfsr_pkg::frame_t'(1) - rsp.data;
		entry_live = rsp.vld && rsp.hit;
		is_exact   = entry_live &&
			(gap == {{(rfsr_pkg::FRAME_W - rfsr_pkg::OFFSET_W){1'b0}}, off});
		is_cand    = entry_live &&
			(gap[rfsr_pkg::FRAME_W-1:rfsr_pkg::NEW_OFF_W] == '0) &&
			({{(rfsr_pkg::OFFSET_W - rfsr_pkg::NEW_OFF_W){1'b0}},
				gap[rfsr_pkg::NEW_OFF_W-1:0]} > off) &&
			({1'b0, gap[rfsr_pkg::NEW_OFF_W-1:0]} < best_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			best_q    <= rfsr_pkg::NO_SUBST;
		end else if (start) begin
			present_q <= 1'b0;
			best_q    <= rfsr_pkg::NO_SUBST;
		end else begin
			if (is_exact) begin
				present_q <= 1'b1;
			end
			if (is_cand) begin
				best_q <= {1'b0, gap[rfsr_pkg::NEW_OFF_W-1:0]};
			end
		end
	end

	assign present = present_q;
	assign best    = best_q;

endmodule

FILE: rtl/reference_frame_store_resolver.sv
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    opcode, frame_number, ref_offset
// result    out        result_valid / result_stall status, new_offset
//
// Add, and resolve with no reference: the item goes from S_IDLE to S_DONE and back to S_IDLE.
// Resolve: S_SCAN, then S_LAST and S_DONE; S_SCAN walks the slots in a sequential scan of the
// frame memory through its single read port, one slot per cycle.
// Reset clears the slot valid marks and all control; no clearing pass is needed.
// A new item is taken while a finished result still waits under result_stall.
module reference_frame_store_resolver (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               opcode,
	input  logic [rfsr_pkg::FRAME_W-1:0]       frame_number,
	input  logic [rfsr_pkg::OFFSET_W-1:0]      ref_offset,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [1:0]                         status,
	output logic [rfsr_pkg::NEW_OFF_W-1:0]     new_offset
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_LAST = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_n;

	rfsr_pkg::slot_t scan_idx_q;
	logic scan_q;
	rfsr_pkg::frame_t cur_q;
	logic [rfsr_pkg::OFFSET_W-1:0] off_q;

	logic result_valid_q;
	rfsr_pkg::status_t status_q;
	logic [rfsr_pkg::NEW_OFF_W-1:0] new_offset_q;

	logic accept;
	logic needs_scan;
	logic out_load;
	logic present;
	logic [rfsr_pkg::BEST_W-1:0] best;
	rfsr_pkg::status_t status_n;
	logic [rfsr_pkg::NEW_OFF_W-1:0] new_offset_n;

	rfsr_pkg::store_cmd_t cmd;
	rfsr_pkg::store_rsp_t rsp;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign needs_scan = (rfsr_pkg::op_t'(opcode) == rfsr_pkg::OP_RESOLVE) &&
		(ref_offset != rfsr_pkg::OFFSET_NONE);
	assign out_load   = (state_q == S_DONE) && (!result_valid_q || !result_stall);

	always_comb begin
		cmd.wr_en   = accept && (rfsr_pkg::op_t'(opcode) == rfsr_pkg::OP_ADD);
		cmd.wr_data = frame_number;
		cmd.rd_en   = (state_q == S_SCAN);
		cmd.rd_slot = scan_idx_q;
	end

	rfsr_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	rfsr_match u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.rsp     (rsp),
		.cur     (cur_q),
		.off     (off_q),
		.present (present),
		.best    (best)
	);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_n = needs_scan ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				if (scan_idx_q == rfsr_pkg::slot_t'(rfsr_pkg::NUM_REFS - 1)) begin
					state_n = S_LAST;
				end
			end
			S_LAST: state_n = S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		status_n     = rfsr_pkg::ST_NONE;
		new_offset_n = '0;
		if (scan_q) begin
			priority if (present) begin
				status_n = rfsr_pkg::ST_PRESENT;
			end else if (best != rfsr_pkg::NO_SUBST) begin
				status_n     = rfsr_pkg::ST_SUBST;
				new_offset_n = best[rfsr_pkg::NEW_OFF_W-1:0];
			end else begin
				status_n = rfsr_pkg::ST_MISSING;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			scan_idx_q     <= '0;
			scan_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (accept) begin
				scan_idx_q <= '0;
				scan_q     <= needs_scan;
			end else if (state_q == S_SCAN) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= frame_number;
			off_q <= ref_offset;
		end
		if (out_load) begin
			status_q     <= status_n;
			new_offset_q <= new_offset_n;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign new_offset   = new_offset_q;

endmodule

FILE: rtl/rfsr_checker.sv
module rfsr_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	input  logic                               item_stall,
	input  logic                               opcode,
	input  logic [rfsr_pkg::FRAME_W-1:0]       frame_number,
	input  logic [rfsr_pkg::OFFSET_W-1:0]      ref_offset,
	input  logic                               result_valid,
	input  logic                               result_stall,
	input  logic [1:0]                         status,
	input  logic [rfsr_pkg::NEW_OFF_W-1:0]     new_offset
);

	// hold a stalled result transaction
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(status) && $stable(new_offset))
		else $error("result changed while stalled");

	// one item processed at a time: the block is busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken back to back");

	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != rfsr_pkg::ST_SUBST) |-> new_offset == '0)
		else $error("new_offset set without substitution");

	// a substitute always lies beyond the requested offset, so never at zero
	a_subst_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == rfsr_pkg::ST_SUBST) |-> new_offset != '0)
		else $error("substitute at offset zero");

endmodule

bind reference_frame_store_resolver rfsr_checker u_rfsr_checker (.*);

FILE: tb/sv/tb_reference_frame_store_resolver.sv
`timescale 1ns / 1ps

module tb_reference_frame_store_resolver;
	import rfsr_pkg::*;

	class ref_resolve_scoreboard;
		frame_t                stored[NUM_REFS];
		logic [NUM_REFS-1:0]   held;
		status_t               due_status[$];
		logic [NEW_OFF_W-1:0]  due_offset[$];
		int                    errors;

		function new();
			held = '0;
			errors = 0;
			foreach (stored[i]) stored[i] = '0;
		endfunction

		function bit frame_held(frame_t f);
			for (int s = 0; s < NUM_REFS; s++)
				if (held[s] && stored[s] == f) return 1'b1;
			return 1'b0;
		endfunction

		function void store_frame(frame_t f);
			if (held[0]) begin
				for (int s = NUM_REFS - 1; s > 0; s--) stored[s] = stored[s-1];
				stored[0] = f;
				held = {held[NUM_REFS-2:0], 1'b1};
				return;
			end
			for (int s = NUM_REFS - 1; s >= 0; s--) begin
				if (!held[s]) begin
					stored[s] = f;
					held[s] = 1'b1;
					return;
				end
			end
		endfunction

		// Work out the answer for one accepted transaction and queue it.
		function void note_item(op_t op, frame_t cur, logic [OFFSET_W-1:0] off);
			status_t              st;
			logic [NEW_OFF_W-1:0] subst;
			st = ST_NONE;
			subst = '0;
			if (op == OP_ADD) begin
				store_frame(cur);
			end else if (off != OFFSET_NONE) begin
				if (frame_held(frame_t'(int'(cur) - int'(off) - 1))) begin
					st = ST_PRESENT;
				end else begin
					st = ST_MISSING;
					for (int k = int'(off) + 1; k <= int'(SEARCH_LIMIT); k++) begin
						if (frame_held(frame_t'(int'(cur) - k - 1))) begin
							st = ST_SUBST;
							subst = k[NEW_OFF_W-1:0];
							break;
						end
					end
				end
			end
			due_status.push_back(st);
			due_offset.push_back(subst);
		endfunction

		function void check_result(logic [1:0] st, logic [NEW_OFF_W-1:0] noff);
			status_t              want_st;
			logic [NEW_OFF_W-1:0] want_off;
			if (due_status.size() == 0) begin
				$error("result with no transaction pending: status %0d new_offset %0d",
					st, noff);
				errors++;
				return;
			end
			want_st = due_status.pop_front();
			want_off = due_offset.pop_front();
			if (st !== want_st) begin
				$error("status: expected %0d, actual %0d", want_st, st);
				errors++;
			end
			if (noff !== want_off) begin
				$error("new_offset: expected %0d, actual %0d", want_off, noff);
				errors++;
			end
		endfunction

		function int pending();
			return due_status.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	logic                  opcode;
	logic [FRAME_W-1:0]    frame_number;
	logic [OFFSET_W-1:0]   ref_offset;
	logic                  result_valid;
	logic                  result_stall;
	logic [1:0]            status;
	logic [NEW_OFF_W-1:0]  new_offset;

	ref_resolve_scoreboard sb;
	int                    items_sent;
	bit                    quiet;

	reference_frame_store_resolver u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.frame_number (frame_number),
		.ref_offset   (ref_offset),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.new_offset   (new_offset)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			sb.note_item(op_t'(opcode), frame_number, ref_offset);
		if (arst_n && result_valid && !result_stall)
			sb.check_result(status, new_offset);
	end

	initial begin
		result_stall <= 1'b0;
		forever begin
			@(negedge clk);
			result_stall <= !quiet && ($urandom_range(99) < 34);
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(op_t op, frame_t cur, logic [OFFSET_W-1:0] off);
		while (!quiet && $urandom_range(99) < 34) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		frame_number <= cur;
		ref_offset <= off;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);
		items_sent++;
		quiet = (items_sent >= 600 && items_sent < 900);
	endtask

	task automatic send_resolve(frame_t cur);
		int                  pick;
		logic [OFFSET_W-1:0] off;
		pick = $urandom_range(99);
		if (pick < 70)
			off = 8'($urandom_range(15));
		else if (pick < 80)
			off = OFFSET_NONE;
		else
			off = 8'($urandom_range(254));
		send_item(OP_RESOLVE, cur, off);
	endtask

	initial begin
		frame_t fr;
		sb = new();
		items_sent = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		item_valid <= 1'b0;
		opcode <= OP_ADD;
		frame_number <= '0;
		ref_offset <= '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty store
		send_item(OP_RESOLVE, 16'd0, 8'd0);
		send_item(OP_RESOLVE, 16'd0, OFFSET_NONE);
		send_item(OP_ADD, 16'hffff, 8'hff);
		send_item(OP_ADD, 16'h0000, 8'h00);
		send_item(OP_ADD, 16'd5, 8'h5a);
		// target wraps below zero
		send_item(OP_RESOLVE, 16'd2, 8'd2);
		send_item(OP_RESOLVE, 16'd1, 8'd0);
		send_item(OP_RESOLVE, 16'd10, 8'd3);
		// offset at the search limit, and beyond it
		send_item(OP_RESOLVE, 16'd10, 8'd15);
		send_item(OP_RESOLVE, 16'd20, 8'd254);
		send_item(OP_RESOLVE, 16'd4, 8'd254);
		send_item(OP_RESOLVE, 16'd16, 8'd14);
		for (int i = 0; i < 10; i++)
			send_item(OP_ADD, frame_t'(16'h8000 + i), 8'(i * 29));
		send_item(OP_RESOLVE, 16'h800a, 8'd0);
		send_item(OP_RESOLVE, 16'h8014, 8'd3);
		send_item(OP_RESOLVE, 16'hffff, 8'hff);

		// Stream of frames near the wrap point, with lost frames and noise.
		fr = 16'hffc0;
		while (items_sent < 1550) begin
			if ($urandom_range(99) < 15) begin
				send_item(op_t'($urandom_range(1)), frame_t'($urandom),
					8'($urandom_range(255)));
			end else begin
				if ($urandom_range(9) != 0)
					send_item(OP_ADD, fr, 8'($urandom_range(255)));
				fr++;
				send_resolve(fr);
				if ($urandom_range(99) == 0)
					fr = frame_t'($urandom);
			end
		end
		item_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#1_500_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
